>>> hw/rtl/rpog_pkg.sv
// ----------------------------------------------------------------------------
// rpog_pkg: shared types and constants of the point residual outlier gate
// Holds the word layouts of both channels, the register set, the register
// indexes and the widths of the intermediate values of the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rpog_pkg;

  // Number of register stages from input acceptance to the output register.
  localparam int unsigned NumStages = 7;

  // Datapath widths.
  localparam int unsigned QuatW  = 16;  // Q2.14 quaternion component
  localparam int unsigned QprodW = 32;  // product of two components
  localparam int unsigned CoordW = 32;  // Q16.16 coordinate
  localparam int unsigned DiffW  = 33;  // landmark minus position
  localparam int unsigned ElemW  = 34;  // Q6.28 rotation matrix entry
  localparam int unsigned ProdW  = 67;  // entry times difference
  localparam int unsigned SumW   = 69;  // exact dot product
  localparam int unsigned CamW   = 40;  // camera-frame coordinate, Q24.16
  localparam int unsigned OffW   = 17;  // pixel minus principal point
  localparam int unsigned PixW   = 16;  // Q12.4 pixel coordinate
  localparam int unsigned DepthW = 24;  // Q8.16 depth
  localparam int unsigned MagW   = 40;  // |offset| times depth
  localparam int unsigned PartW  = 56;  // |offset| * depth * 16-bit half
  localparam int unsigned BpSumW = 57;  // rounded back-projection sum
  localparam int unsigned BpMagW = 37;  // back-projection magnitude
  localparam int unsigned ObsW   = 38;  // signed back-projection
  localparam int unsigned ResW   = 41;  // unsaturated residual
  localparam int unsigned SqW    = 64;  // squared terms and their sum
  localparam int unsigned CfgW   = 32;  // configuration data width
  localparam int unsigned CfgIdxW = 3;

  // Fixed-point constants.
  localparam logic signed [ElemW-1:0] OneQ28  = ElemW'(2 ** 28);
  localparam logic signed [SumW-1:0]  HalfQ28 = SumW'(2 ** 27);
  localparam logic [BpSumW-1:0]       BpRound = BpSumW'(2 ** 19);

  // Register indexes.
  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  localparam cfg_idx_t CfgPrincipalX  = 3'd0;
  localparam cfg_idx_t CfgPrincipalY  = 3'd1;
  localparam cfg_idx_t CfgInvFocalX   = 3'd2;
  localparam cfg_idx_t CfgInvFocalY   = 3'd3;
  localparam cfg_idx_t CfgOutlierLim  = 3'd4;

  // Register values after reset (limit is 0.15 squared in Q0.32).
  localparam logic [15:0] RstPrincipalX = 16'd5112;
  localparam logic [15:0] RstPrincipalY = 16'd3832;
  localparam logic [31:0] RstInvFocal   = 32'd8181066;
  localparam logic [31:0] RstOutlierLim = 32'd96636764;

  typedef struct packed {
    logic [15:0] principal_x;
    logic [15:0] principal_y;
    logic [31:0] inv_focal_x;
    logic [31:0] inv_focal_y;
    logic [31:0] outlier_limit;
  } cfg_t;

  // Input word: one observation.
  typedef struct packed {
    logic signed [QuatW-1:0]  quat_w;
    logic signed [QuatW-1:0]  quat_x;
    logic signed [QuatW-1:0]  quat_y;
    logic signed [QuatW-1:0]  quat_z;
    logic signed [CoordW-1:0] pose_x;
    logic signed [CoordW-1:0] pose_y;
    logic signed [CoordW-1:0] pose_z;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
    logic [31:0]              pixel_uv;
    logic [DepthW-1:0]        depth;
  } in_word_t;

  // Output word: residual, its squared norm and the outlier flag.
  typedef struct packed {
    logic signed [CoordW-1:0] residual_x;
    logic signed [CoordW-1:0] residual_y;
    logic signed [CoordW-1:0] residual_z;
    logic [SqW-1:0]           squared_error;
    logic                     is_outlier;
  } out_word_t;

  typedef logic signed [CamW-1:0] cam_t;
  typedef logic signed [ObsW-1:0] obs_t;

  // Load enables of the pipeline stages; s1 is the first stage.
  typedef struct packed {
    logic s7;
    logic s6;
    logic s5;
    logic s4;
    logic s3;
    logic s2;
    logic s1;
  } stage_en_t;

endpackage

`default_nettype wire

>>> hw/rtl/rpog_in_if.sv
// ----------------------------------------------------------------------------
// rpog_in_if: observation channel
// Valid/ready channel that carries one observation word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpog_in_if;
  import rpog_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rpog_out_if.sv
// ----------------------------------------------------------------------------
// rpog_out_if: result channel
// Valid/ready channel that carries one result word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpog_out_if;
  import rpog_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rpog_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// rpog_pipe_ctrl: valid bits and load enables of the pipeline
// Each stage loads when it is empty or when the stage after it loads, so
// bubbles close up under backpressure and nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module rpog_pipe_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output rpog_pkg::stage_en_t      en_o
);
  import rpog_pkg::*;

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] valid_d;
  logic [NumStages:0]   load;

  // A stage may load when it is empty or its contents move on.
  assign load[NumStages] = out_ready_i;
  for (genvar k = 0; k < NumStages; k++) begin : g_stage
    assign load[k] = !valid_q[k] || load[k+1];
    if (k == 0) begin : g_first
      assign valid_d[k] = load[k] ? in_valid_i : valid_q[k];
    end else begin : g_rest
      assign valid_d[k] = load[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = load[0];
  assign out_valid_o = valid_q[NumStages-1];
  assign en_o        = stage_en_t'(load[NumStages-1:0]);

endmodule

`default_nettype wire

>>> hw/rtl/rpog_rotate.sv
// ----------------------------------------------------------------------------
// rpog_rotate: camera-frame landmark
// Four stages: quaternion products and position difference, conjugate
// rotation matrix in Q6.28, nine entry-by-difference products, and the three
// exact dot products rounded half up to Q24.16.
// ----------------------------------------------------------------------------
`default_nettype none

module rpog_rotate (
  input  wire logic                clk_i,
  input  wire rpog_pkg::stage_en_t en_i,
  input  wire rpog_pkg::in_word_t  word_i,
  output rpog_pkg::cam_t           cam_o [3]
);
  import rpog_pkg::*;

  // Stage 1: component products and landmark minus position.
  logic signed [QprodW-1:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  logic signed [DiffW-1:0]  diff1_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      xx_q <= $signed(word_i.quat_x) * $signed(word_i.quat_x);
      yy_q <= $signed(word_i.quat_y) * $signed(word_i.quat_y);
      zz_q <= $signed(word_i.quat_z) * $signed(word_i.quat_z);
      xy_q <= $signed(word_i.quat_x) * $signed(word_i.quat_y);
      xz_q <= $signed(word_i.quat_x) * $signed(word_i.quat_z);
      yz_q <= $signed(word_i.quat_y) * $signed(word_i.quat_z);
      wx_q <= $signed(word_i.quat_w) * $signed(word_i.quat_x);
      wy_q <= $signed(word_i.quat_w) * $signed(word_i.quat_y);
      wz_q <= $signed(word_i.quat_w) * $signed(word_i.quat_z);
      diff1_q[0] <= DiffW'($signed(word_i.point_x)) - DiffW'($signed(word_i.pose_x));
      diff1_q[1] <= DiffW'($signed(word_i.point_y)) - DiffW'($signed(word_i.pose_y));
      diff1_q[2] <= DiffW'($signed(word_i.point_z)) - DiffW'($signed(word_i.pose_z));
    end
  end

  // Stage 2: rotation matrix of the conjugate, unit-norm form.
  logic signed [ElemW-1:0] elem_d [3][3];
  logic signed [ElemW-1:0] elem_q [3][3];
  logic signed [DiffW-1:0] diff2_q [3];

  always_comb begin
    elem_d[0][0] = OneQ28 - ((ElemW'(yy_q) + ElemW'(zz_q)) <<< 1);
    elem_d[0][1] = (ElemW'(xy_q) + ElemW'(wz_q)) <<< 1;
    elem_d[0][2] = (ElemW'(xz_q) - ElemW'(wy_q)) <<< 1;
    elem_d[1][0] = (ElemW'(xy_q) - ElemW'(wz_q)) <<< 1;
    elem_d[1][1] = OneQ28 - ((ElemW'(xx_q) + ElemW'(zz_q)) <<< 1);
    elem_d[1][2] = (ElemW'(yz_q) + ElemW'(wx_q)) <<< 1;
    elem_d[2][0] = (ElemW'(xz_q) + ElemW'(wy_q)) <<< 1;
    elem_d[2][1] = (ElemW'(yz_q) - ElemW'(wx_q)) <<< 1;
    elem_d[2][2] = OneQ28 - ((ElemW'(xx_q) + ElemW'(yy_q)) <<< 1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      elem_q  <= elem_d;
      diff2_q <= diff1_q;
    end
  end

  // Stage 3: one product per matrix entry.
  logic signed [ProdW-1:0] prod_q [3][3];

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= elem_q[r][c] * diff2_q[c];
        end
      end
    end
  end

  // Stage 4: exact row sums, rounded once with half toward plus infinity.
  logic signed [SumW-1:0] sum_d [3];
  cam_t                   cam_q [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_d[r] = SumW'(prod_q[r][0]) + SumW'(prod_q[r][1]) + SumW'(prod_q[r][2]) + HalfQ28;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      for (int r = 0; r < 3; r++) begin
        cam_q[r] <= CamW'(sum_d[r] >>> 28);
      end
    end
  end

  assign cam_o = cam_q;

endmodule

`default_nettype wire

>>> hw/rtl/rpog_backproj.sv
// ----------------------------------------------------------------------------
// rpog_backproj: observed point from pixel and depth
// Four stages: offset from the principal point, magnitude times depth, two
// 16-bit halves of the reciprocal focal length, and the rounded, signed sum.
// The z observation is the depth itself, carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module rpog_backproj (
  input  wire logic                clk_i,
  input  wire rpog_pkg::stage_en_t en_i,
  input  wire rpog_pkg::cfg_t      cfg_i,
  input  wire rpog_pkg::in_word_t  word_i,
  output rpog_pkg::obs_t           obs_o [2],
  output logic [rpog_pkg::DepthW-1:0] depth_o
);
  import rpog_pkg::*;

  // Stage 1: signed offsets from the principal point.
  logic signed [OffW-1:0] off_q [2];
  logic [DepthW-1:0]      dep1_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      off_q[0] <= $signed({1'b0, word_i.pixel_uv[PixW-1:0]}) -
                  $signed({1'b0, cfg_i.principal_x});
      off_q[1] <= $signed({1'b0, word_i.pixel_uv[2*PixW-1:PixW]}) -
                  $signed({1'b0, cfg_i.principal_y});
      dep1_q   <= word_i.depth;
    end
  end

  // Stage 2: offset magnitude times depth, sign kept aside.
  logic [PixW-1:0]   off_abs [2];
  logic [MagW-1:0]   mag_q   [2];
  logic [1:0]        neg2_q;
  logic [DepthW-1:0] dep2_q;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      off_abs[a] = off_q[a][OffW-1] ? PixW'(-off_q[a]) : off_q[a][PixW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      for (int a = 0; a < 2; a++) begin
        mag_q[a]  <= off_abs[a] * dep1_q;
        neg2_q[a] <= off_q[a][OffW-1];
      end
      dep2_q <= dep1_q;
    end
  end

  // Stage 3: partial products with the upper and lower halves of 1/f.
  logic [PartW-1:0]  hi_q [2];
  logic [PartW-1:0]  lo_q [2];
  logic [1:0]        neg3_q;
  logic [DepthW-1:0] dep3_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      hi_q[0] <= mag_q[0] * cfg_i.inv_focal_x[31:16];
      lo_q[0] <= mag_q[0] * cfg_i.inv_focal_x[15:0];
      hi_q[1] <= mag_q[1] * cfg_i.inv_focal_y[31:16];
      lo_q[1] <= mag_q[1] * cfg_i.inv_focal_y[15:0];
      neg3_q  <= neg2_q;
      dep3_q  <= dep2_q;
    end
  end

  // Stage 4: round the magnitude half away from zero, then apply the sign.
  logic [BpSumW-1:0] bp_sum [2];
  logic [BpMagW-1:0] bp_mag [2];
  obs_t              obs_q  [2];
  logic [DepthW-1:0] dep4_q;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      bp_sum[a] = BpSumW'(hi_q[a]) + BpSumW'(lo_q[a] >> 16) + BpRound;
      bp_mag[a] = bp_sum[a][BpSumW-1:20];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      for (int a = 0; a < 2; a++) begin
        obs_q[a] <= neg3_q[a] ? -$signed({1'b0, bp_mag[a]}) : $signed({1'b0, bp_mag[a]});
      end
      dep4_q <= dep3_q;
    end
  end

  assign obs_o   = obs_q;
  assign depth_o = dep4_q;

endmodule

`default_nettype wire

>>> hw/rtl/rpog_residual.sv
// ----------------------------------------------------------------------------
// rpog_residual: saturated residual, squared norm and outlier flag
// Three stages: difference and saturation, squares, and the sum with the
// threshold compare into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rpog_residual (
  input  wire logic                   clk_i,
  input  wire rpog_pkg::stage_en_t    en_i,
  input  wire rpog_pkg::cfg_t         cfg_i,
  input  wire rpog_pkg::cam_t         cam_i [3],
  input  wire rpog_pkg::obs_t         obs_i [2],
  input  wire logic [rpog_pkg::DepthW-1:0] depth_i,
  output rpog_pkg::out_word_t         word_o
);
  import rpog_pkg::*;

  localparam logic signed [ResW-1:0] SatHi = ResW'(32'sh7fff_ffff);
  localparam logic signed [ResW-1:0] SatLo = ResW'(32'sh8000_0000);

  // Stage 5: residual per axis, clamped to 32 bits, and its magnitude.
  logic signed [ResW-1:0]   obs_w  [3];
  logic signed [ResW-1:0]   diff_d [3];
  logic signed [CoordW-1:0] res_d  [3];
  logic [CoordW-1:0]        mag_d  [3];
  logic signed [CoordW-1:0] res5_q [3];
  logic [CoordW-1:0]        mag5_q [3];

  always_comb begin
    obs_w[0] = ResW'(obs_i[0]);
    obs_w[1] = ResW'(obs_i[1]);
    obs_w[2] = $signed({{(ResW-DepthW){1'b0}}, depth_i});
    for (int a = 0; a < 3; a++) begin
      diff_d[a] = ResW'(cam_i[a]) - obs_w[a];
      if (diff_d[a] > SatHi) begin
        res_d[a] = CoordW'(SatHi);
      end else if (diff_d[a] < SatLo) begin
        res_d[a] = CoordW'(SatLo);
      end else begin
        res_d[a] = CoordW'(diff_d[a]);
      end
      mag_d[a] = res_d[a][CoordW-1] ? (~res_d[a] + 1'b1) : res_d[a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s5) begin
      res5_q <= res_d;
      mag5_q <= mag_d;
    end
  end

  // Stage 6: squares.
  logic signed [CoordW-1:0] res6_q [3];
  logic [SqW-1:0]           sq_q   [3];

  always_ff @(posedge clk_i) begin
    if (en_i.s6) begin
      for (int a = 0; a < 3; a++) begin
        sq_q[a] <= mag5_q[a] * mag5_q[a];
      end
      res6_q <= res5_q;
    end
  end

  // Stage 7: squared norm (three terms at most 2^62 each) and threshold test.
  logic [SqW-1:0] norm_d;
  out_word_t      word_q;

  assign norm_d = sq_q[0] + sq_q[1] + sq_q[2];

  always_ff @(posedge clk_i) begin
    if (en_i.s7) begin
      word_q.residual_x    <= res6_q[0];
      word_q.residual_y    <= res6_q[1];
      word_q.residual_z    <= res6_q[2];
      word_q.squared_error <= norm_d;
      word_q.is_outlier    <= norm_d > SqW'(cfg_i.outlier_limit);
    end
  end

  assign word_o = word_q;

endmodule

`default_nettype wire

>>> hw/rtl/rgbd_point_residual_outlier_gate_unit.sv
// ----------------------------------------------------------------------------
// rgbd_point_residual_outlier_gate_unit: point residual with outlier gate
// Rotates landmark minus keyframe position into the camera frame, subtracts
// the back-projected keypoint and flags residuals whose squared norm exceeds
// the programmed limit.
//
//   Channel   Dir  Word                              Handshake
//   in_i      in   one observation (in_word_t)       valid / ready
//   res_o     out  residual, norm, flag (out_word_t) valid / ready
//   cfg       in   register index, 32-bit data       cfg_we_i, no wait
//
// One word is accepted per cycle while in_i.ready is high. The first of the
// seven register stages loads at the accepting edge, and the result word is
// presented from the seventh stage, the output register.
// Reset clears the stage valid bits and loads the registers' default values.
// Under backpressure each stage holds its word and empty stages keep filling,
// so in_i.ready falls only once every stage holds a word.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbd_point_residual_outlier_gate_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  rpog_in_if.sink                         in_i,
  rpog_out_if.source                      res_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [rpog_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [rpog_pkg::CfgW-1:0]  cfg_data_i
);
  import rpog_pkg::*;

  // Configuration registers; writes to unused indexes are dropped.
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.principal_x   <= RstPrincipalX;
      cfg_q.principal_y   <= RstPrincipalY;
      cfg_q.inv_focal_x   <= RstInvFocal;
      cfg_q.inv_focal_y   <= RstInvFocal;
      cfg_q.outlier_limit <= RstOutlierLim;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPrincipalX: cfg_q.principal_x   <= cfg_data_i[15:0];
        CfgPrincipalY: cfg_q.principal_y   <= cfg_data_i[15:0];
        CfgInvFocalX:  cfg_q.inv_focal_x   <= cfg_data_i;
        CfgInvFocalY:  cfg_q.inv_focal_y   <= cfg_data_i;
        CfgOutlierLim: cfg_q.outlier_limit <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Pipeline control.
  stage_en_t en;

  rpog_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .en_o        (en)
  );

  // Camera-frame landmark.
  cam_t cam [3];

  rpog_rotate u_rotate (
    .clk_i  (clk_i),
    .en_i   (en),
    .word_i (in_i.data),
    .cam_o  (cam)
  );

  // Back-projected keypoint.
  obs_t              obs [2];
  logic [DepthW-1:0] depth;

  rpog_backproj u_backproj (
    .clk_i   (clk_i),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .word_i  (in_i.data),
    .obs_o   (obs),
    .depth_o (depth)
  );

  // Residual, norm and flag into the output register.
  rpog_residual u_residual (
    .clk_i   (clk_i),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .cam_i   (cam),
    .obs_i   (obs),
    .depth_i (depth),
    .word_o  (res_o.data)
  );

endmodule

`default_nettype wire
